### design/sbe_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sbe_pkg
// Shared types, opcodes, error codes and controller commands for the
// stack bytecode executor.
// ---------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam logic [4:0] OP_NEG    = 5'd0;
  localparam logic [4:0] OP_ADD    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_MUL    = 5'd3;
  localparam logic [4:0] OP_DIV    = 5'd4;
  localparam logic [4:0] OP_REM    = 5'd5;
  localparam logic [4:0] OP_NOT    = 5'd6;
  localparam logic [4:0] OP_EQ     = 5'd7;
  localparam logic [4:0] OP_NEQ    = 5'd8;
  localparam logic [4:0] OP_LT     = 5'd9;
  localparam logic [4:0] OP_LTE    = 5'd10;
  localparam logic [4:0] OP_GT     = 5'd11;
  localparam logic [4:0] OP_GTE    = 5'd12;
  localparam logic [4:0] OP_AND    = 5'd13;
  localparam logic [4:0] OP_OR     = 5'd14;
  localparam logic [4:0] OP_LOAD   = 5'd15;
  localparam logic [4:0] OP_SETLOC = 5'd16;
  localparam logic [4:0] OP_INT    = 5'd17;
  localparam logic [4:0] OP_TRUE   = 5'd18;
  localparam logic [4:0] OP_PUSHF  = 5'd19;
  localparam logic [4:0] OP_JIF    = 5'd20;
  localparam logic [4:0] OP_JUMP   = 5'd21;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_DIVZERO   = 3'd3;
  localparam logic [2:0] ERR_BADLOCAL  = 3'd4;
  localparam logic [2:0] ERR_BADTARGET = 3'd5;
  localparam logic [2:0] ERR_BADOP     = 3'd6;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] operand;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [8:0]         depth;
    logic               redirect;
    logic [15:0]        redirect_target;
    logic [2:0]         error;
  } out_beat_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;   // latch the input beat, apply restart
    logic rd_ops;    // read the top entry and the second (or the local for load)
    logic exec;      // evaluate the instruction
    logic div_start; // launch the divider
    logic commit;    // write back and form the result
    logic rd_top;    // read new top entry
    logic finish;    // load the output register
  } sbe_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic clearing;  // memory clearing pass after reset
  } sbe_sts_t;

endpackage
`default_nettype wire

### design/sbe_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sbe_div
// Radix-2 restoring divider, signed truncating, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module sbe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);

  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] r_shift;
  logic [32:0] r_sub;

  assign r_shift = {r[31:0], q[31]};
  assign r_sub   = r_shift - {1'b0, d};

  // iterate over magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd32;
        neg_q <= dividend[31] ^ divisor[31];
        neg_r <= dividend[31];
        q     <= dividend[31] ? (32'd0 - dividend) : dividend;
        d     <= divisor[31] ? (32'd0 - divisor) : divisor;
        r     <= '0;
      end else if (busy) begin
        if (r_sub[32]) begin
          r <= r_shift;
          q <= {q[30:0], 1'b0};
        end else begin
          r <= r_sub;
          q <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix-up
  assign quotient  = neg_q ? (32'd0 - q) : q;
  assign remainder = neg_r ? (32'd0 - r[31:0]) : r[31:0];

endmodule
`default_nettype wire

### design/sbe_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sbe_ctrl
// Sequencer: capture, operand read, execute (then divide if needed), commit,
// top read, output.
// ---------------------------------------------------------------------------
module sbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             out_busy,
  input  wire sbe_pkg::sbe_sts_t sts,
  output sbe_pkg::sbe_cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_COMMIT= 7'b0010000,
    S_TOP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = sts.clearing;
        if (in_valid && !sts.clearing) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_ops = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.rd_top = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### design/sbe_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sbe_dp
// Datapath: stack memory, pointer, ALU, checks, divider and result register.
// ---------------------------------------------------------------------------
module sbe_dp #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_data,
  input  wire sbe_pkg::in_beat_t in_beat,
  input  wire sbe_pkg::sbe_cmd_t cmd,
  output sbe_pkg::sbe_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sbe_pkg::out_beat_t     out_beat
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = AW + 1;

  // stack memory, zeroed by a clearing pass after reset
  logic [31:0]   mem [STACK_DEPTH];
  logic [AW-1:0] clr_idx;
  logic          clearing;

  logic [6:0]    num_locals;
  logic [PW-1:0] sp;
  logic [PW-1:0] nl;
  logic [PW-1:0] above;

  logic [4:0]    op;
  logic [31:0]   operand;

  logic [31:0]   a, b;       // second (or local for load) and top entries
  logic [31:0]   res;
  logic [2:0]    err;
  logic          redir;
  logic [15:0]   tgt;
  logic          do_write;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] sp_new;
  logic [31:0]   top;

  logic          div_done;
  logic          need_div;
  logic [31:0]   quo, rmd;
  logic [31:0]   prod;

  // effective locals clamp
  always_comb begin
    if ({25'd0, num_locals} > STACK_DEPTH) nl = PW'(STACK_DEPTH);
    else nl = PW'(num_locals);
  end
  assign above = (sp > nl) ? (sp - nl) : '0;

  always_ff @(posedge clk) begin
    if (rst) num_locals <= '0;
    else if (cfg_we) num_locals <= cfg_data;
  end

  // clearing pass over every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(STACK_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  logic [AW-1:0] ia, ib, il, ra;
  assign ib = AW'(sp - PW'(1));
  assign ia = AW'(sp - PW'(2));
  assign il = operand[AW-1:0];
  assign ra = (op == sbe_pkg::OP_LOAD) ? il : ia;

  // capture and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      if (cmd.capture) begin
        op      <= in_beat.op;
        operand <= in_beat.operand;
        if (in_beat.restart) sp <= nl;
      end
      if (cmd.commit) sp <= sp_new;
    end
  end

  // memory reads and writes
  always_ff @(posedge clk) begin
    if (cmd.rd_ops) begin
      b <= mem[ib];
      a <= mem[ra];
    end
    if (cmd.exec) prod <= a * b;
    if (clearing) mem[clr_idx] <= '0;
    else if (cmd.commit && do_write) mem[wr_addr] <= res;
    if (cmd.rd_top) top <= mem[ib];
  end

  assign need_div = (op == sbe_pkg::OP_DIV || op == sbe_pkg::OP_REM) &&
                    (above >= PW'(2)) && (b != 32'd0);

  sbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (quo),
    .remainder(rmd)
  );

  // status to the controller
  always_comb begin
    sts.need_div = need_div;
    sts.div_done = div_done;
    sts.clearing = clearing;
  end

  // instruction evaluation (operands from registers)
  always_comb begin
    logic bad_local;
    logic full;
    logic bad_tgt;
    bad_local = ({1'b0, operand} >= {{(33-PW){1'b0}}, nl});
    full      = (sp >= PW'(STACK_DEPTH));
    bad_tgt   = (operand > 32'h0000_FFFF);
    err      = sbe_pkg::ERR_OK;
    res      = '0;
    redir    = 1'b0;
    tgt      = '0;
    do_write = 1'b0;
    wr_addr  = ib;
    sp_new   = sp;
    case (op)
      sbe_pkg::OP_NEG, sbe_pkg::OP_NOT: begin
        if (above < PW'(1)) err = sbe_pkg::ERR_UNDERFLOW;
        else begin
          res      = (op == sbe_pkg::OP_NEG) ? (32'd0 - b) : {31'd0, b == 32'd0};
          do_write = 1'b1;
        end
      end
      sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
      sbe_pkg::OP_REM, sbe_pkg::OP_EQ, sbe_pkg::OP_NEQ, sbe_pkg::OP_LT,
      sbe_pkg::OP_LTE, sbe_pkg::OP_GT, sbe_pkg::OP_GTE, sbe_pkg::OP_AND,
      sbe_pkg::OP_OR: begin
        if (above < PW'(2)) err = sbe_pkg::ERR_UNDERFLOW;
        else if ((op == sbe_pkg::OP_DIV || op == sbe_pkg::OP_REM) && b == 32'd0)
          err = sbe_pkg::ERR_DIVZERO;
        else begin
          case (op)
            sbe_pkg::OP_ADD: res = a + b;
            sbe_pkg::OP_SUB: res = a - b;
            sbe_pkg::OP_MUL: res = prod;
            sbe_pkg::OP_DIV: res = quo;
            sbe_pkg::OP_REM: res = rmd;
            sbe_pkg::OP_EQ:  res = {31'd0, a == b};
            sbe_pkg::OP_NEQ: res = {31'd0, a != b};
            sbe_pkg::OP_LT:  res = {31'd0, $signed(a) <  $signed(b)};
            sbe_pkg::OP_LTE: res = {31'd0, $signed(a) <= $signed(b)};
            sbe_pkg::OP_GT:  res = {31'd0, $signed(a) >  $signed(b)};
            sbe_pkg::OP_GTE: res = {31'd0, $signed(a) >= $signed(b)};
            sbe_pkg::OP_AND: res = {31'd0, (a != 32'd0) && (b != 32'd0)};
            default:         res = {31'd0, (a != 32'd0) || (b != 32'd0)};
          endcase
          do_write = 1'b1;
          wr_addr  = ia;
          sp_new   = sp - PW'(1);
        end
      end
      sbe_pkg::OP_LOAD: begin
        if (bad_local) err = sbe_pkg::ERR_BADLOCAL;
        else if (full) err = sbe_pkg::ERR_OVERFLOW;
        else begin
          res = a; do_write = 1'b1; wr_addr = AW'(sp); sp_new = sp + PW'(1);
        end
      end
      sbe_pkg::OP_SETLOC: begin
        if (above < PW'(1)) err = sbe_pkg::ERR_UNDERFLOW;
        else if (bad_local) err = sbe_pkg::ERR_BADLOCAL;
        else begin
          res = b; do_write = 1'b1; wr_addr = il; sp_new = sp - PW'(1);
        end
      end
      sbe_pkg::OP_INT, sbe_pkg::OP_TRUE, sbe_pkg::OP_PUSHF: begin
        if (full) err = sbe_pkg::ERR_OVERFLOW;
        else begin
          res = (op == sbe_pkg::OP_INT) ? operand :
                ((op == sbe_pkg::OP_TRUE) ? 32'd1 : 32'd0);
          do_write = 1'b1; wr_addr = AW'(sp); sp_new = sp + PW'(1);
        end
      end
      sbe_pkg::OP_JIF: begin
        if (above < PW'(1)) err = sbe_pkg::ERR_UNDERFLOW;
        else if (bad_tgt) err = sbe_pkg::ERR_BADTARGET;
        else begin
          if (b == 32'd0) begin
            redir = 1'b1; tgt = operand[15:0];
          end
          sp_new = sp - PW'(1);
        end
      end
      sbe_pkg::OP_JUMP: begin
        if (bad_tgt) err = sbe_pkg::ERR_BADTARGET;
        else begin
          redir = 1'b1; tgt = operand[15:0];
        end
      end
      default: err = sbe_pkg::ERR_BADOP;
    endcase
  end

  // result hold until output load
  logic [2:0]  err_q;
  logic        redir_q;
  logic [15:0] tgt_q;
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      err_q   <= err;
      redir_q <= redir;
      tgt_q   <= tgt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.finish) begin
      out_beat.top_value       <= (sp > nl) ? top : 32'd0;
      out_beat.depth           <= 9'(sp);
      out_beat.redirect        <= redir_q;
      out_beat.redirect_target <= tgt_q;
      out_beat.error           <= err_q;
    end
  end

endmodule
`default_nettype wire

### design/stack_bytecode_executor.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stack_bytecode_executor
// 32-bit stack machine: executes one bytecode instruction per input beat.
// ---------------------------------------------------------------------------
// Each input beat runs one instruction and yields one result beat. The result
// is formed in order by the operand read, execute, write back, top read and
// output load steps, and the next input beat is taken only once the output
// has been loaded; divide and remainder add a pass through the one-bit-per-cycle
// divider, and a stalled result beat holds off the next output load until it
// leaves. After reset the stack memory is zeroed by a clearing pass over every
// entry, during which input stalls.
// The memory is read at up to two addresses and written at one per cycle.
module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sbe_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sbe_pkg::out_beat_t     out_data
);

  sbe_pkg::sbe_cmd_t cmd;
  sbe_pkg::sbe_sts_t sts;

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_valid && out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbe_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_beat  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_data)
  );

  // a result beat is never produced while accepting a new one
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> in_stall) else $error("finish while accepting");

  // error beats never redirect
  a_err_no_redir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error != sbe_pkg::ERR_OK) |-> !out_data.redirect)
    else $error("redirect on error");

  // depth stays within the stack
  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({23'd0, out_data.depth} <= STACK_DEPTH))
    else $error("depth out of range");

endmodule
`default_nettype wire
